@@ hw/rtl/uart_rb_pkg.sv @@
// Package for the UART register block: item and result types, register
// offsets, item kinds and register bit constants.
// No dependencies; used by uart_rb_ctrl and uart_register_block_top.
package uart_rb_pkg;

  // kinds of input item
  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_LINE  = 2'd2,
    KIND_DONE  = 2'd3
  } kind_e;

  // register numbers after the stride shift
  typedef enum logic [2:0] {
    REG_DATA = 3'd0,
    REG_IER  = 3'd1,
    REG_FIFO = 3'd2,
    REG_LCR  = 3'd3,
    REG_MCR  = 3'd4,
    REG_LSR  = 3'd5,
    REG_MSR  = 3'd6,
    REG_SCR  = 3'd7
  } reg_e;

  // configuration register indexes
  localparam logic CFG_STRIDE = 1'b0;

  // register bit constants
  localparam int unsigned LCR_DLAB_BIT = 7;
  localparam logic [7:0] IIR_FIFO_ON   = 8'hC1;
  localparam logic [7:0] IIR_FIFO_OFF  = 8'h01;
  localparam logic [7:0] IER_MASK      = 8'h0F;
  localparam logic [7:0] MCR_MASK      = 8'h1F;
  localparam logic [7:0] LSR_DR        = 8'h01;
  localparam logic [7:0] LSR_OE        = 8'h02;
  localparam logic [7:0] LSR_TXQ_EMPTY = 8'h20;
  localparam logic [7:0] LSR_TEMT      = 8'h40;
  localparam int unsigned FCR_EN_BIT   = 0;
  localparam int unsigned FCR_RXCLR_BIT = 1;
  localparam int unsigned FCR_TXCLR_BIT = 2;

  // input item
  typedef struct packed {
    kind_e       kind;
    logic [5:0]  byte_offset;
    logic [7:0]  write_data;
    logic [7:0]  line_byte;
  } item_t;

  // result item
  typedef struct packed {
    logic [7:0]  read_data;
    logic        send_valid;
    logic [7:0]  send_byte;
  } result_t;

  // what the read stage needs to finish a result
  typedef struct packed {
    logic        rd_from_rx;
    logic [7:0]  rd_const;
    logic        send_valid;
    logic        sb_from_tx;
    logic [7:0]  sb_const;
  } meta_t;

endpackage

@@ hw/rtl/uart_register_block_top.sv @@
// Top level of the UART register block: configuration port, item pipeline,
// receive and transmit queue RAMs and output register.
// Depends on uart_rb_pkg, uart_rb_ctrl and uart_rb_ram.
//
// The block takes one item per clock cycle unless its input is stalled behind
// a held read stage. Each item is decoded and its register and queue pointer
// updates are made in the cycle it is accepted; a queue pop reads the queue
// RAM into its registered read port as the item enters the read stage, and
// the result then sits in the output register. The output register lets a
// new item in while a finished result waits to be taken. The queues need no
// clearing pass after reset: entries are only ever read below the fill count.
// The register stride is set through the configuration port at byte address 0.
module uart_register_block_top #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  uart_rb_pkg::item_t    in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output uart_rb_pkg::result_t  out_item_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

  logic [1:0] stride_q;
  logic       cfg_write;

  logic                 accept;
  uart_rb_pkg::meta_t   meta;
  logic                 s1_valid_q, s1_adv;
  uart_rb_pkg::meta_t   s1_meta_q;
  logic                 out_valid_q;
  uart_rb_pkg::result_t out_item_q, s1_result;

  logic             rx_we, rx_re, tx_we, tx_re;
  logic [PTR_W-1:0] rx_waddr, rx_raddr, tx_waddr, tx_raddr;
  logic [7:0]       rx_wdata, tx_wdata, rx_rdata, tx_rdata;

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == uart_rb_pkg::CFG_STRIDE);
  assign prdata    = (paddr[2] == uart_rb_pkg::CFG_STRIDE) ? {30'd0, stride_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stride_q <= 2'd0;
    end else if (cfg_write) begin
      stride_q <= pwdata[1:0];
    end
  end

  // handshake: read stage moves on when the output register is free
  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign accept     = in_valid_i && !in_stall_o;

  uart_rb_ctrl #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .item_i     (in_item_i),
    .stride_i   (stride_q),
    .meta_o     (meta),
    .rx_we_o    (rx_we),
    .rx_waddr_o (rx_waddr),
    .rx_wdata_o (rx_wdata),
    .rx_re_o    (rx_re),
    .rx_raddr_o (rx_raddr),
    .tx_we_o    (tx_we),
    .tx_waddr_o (tx_waddr),
    .tx_wdata_o (tx_wdata),
    .tx_re_o    (tx_re),
    .tx_raddr_o (tx_raddr)
  );

  uart_rb_ram #(
    .WIDTH(8),
    .DEPTH(QUEUE_DEPTH)
  ) u_rx_ram (
    .clk_i   (clk_i),
    .we_i    (rx_we),
    .waddr_i (rx_waddr),
    .wdata_i (rx_wdata),
    .re_i    (rx_re),
    .raddr_i (rx_raddr),
    .rdata_o (rx_rdata)
  );

  uart_rb_ram #(
    .WIDTH(8),
    .DEPTH(QUEUE_DEPTH)
  ) u_tx_ram (
    .clk_i   (clk_i),
    .we_i    (tx_we),
    .waddr_i (tx_waddr),
    .wdata_i (tx_wdata),
    .re_i    (tx_re),
    .raddr_i (tx_raddr),
    .rdata_o (tx_rdata)
  );

  // finish the result from ram data or decoded constants
  always_comb begin
    s1_result.read_data  = s1_meta_q.rd_from_rx ? rx_rdata : s1_meta_q.rd_const;
    s1_result.send_valid = s1_meta_q.send_valid;
    s1_result.send_byte  = s1_meta_q.sb_from_tx ? tx_rdata : s1_meta_q.sb_const;
  end

  // read stage and output register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_meta_q <= meta;
    end
    if (s1_adv) begin
      out_item_q <= s1_result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef SYNTHESIS
  // input stalls only behind an occupied read stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled with empty read stage");

  // a held read stage keeps its item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_meta_q)))
    else $error("read stage item lost while held");

  // every queue read belongs to an item entering the read stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rx_re || tx_re) |-> accept)
    else $error("queue read without an accepted item");
`endif

endmodule

@@ hw/rtl/uart_rb_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module uart_rb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/uart_rb_ctrl.sv @@
// Register file and queue pointers of the UART register block; decodes each
// item, updates state and issues the queue RAM accesses.
// Depends on uart_rb_pkg.
module uart_rb_ctrl #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           accept_i,
  input  uart_rb_pkg::item_t             item_i,
  input  logic [1:0]                     stride_i,
  output uart_rb_pkg::meta_t             meta_o,
  output logic                           rx_we_o,
  output logic [$clog2(QUEUE_DEPTH)-1:0] rx_waddr_o,
  output logic [7:0]                     rx_wdata_o,
  output logic                           rx_re_o,
  output logic [$clog2(QUEUE_DEPTH)-1:0] rx_raddr_o,
  output logic                           tx_we_o,
  output logic [$clog2(QUEUE_DEPTH)-1:0] tx_waddr_o,
  output logic [7:0]                     tx_wdata_o,
  output logic                           tx_re_o,
  output logic [$clog2(QUEUE_DEPTH)-1:0] tx_raddr_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SUM_W = CNT_W + 1;

  // head plus count, wrapped once around the queue
  function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] head,
                                                input logic [CNT_W-1:0] cnt);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(head) + SUM_W'(cnt);
    if (sum >= SUM_W'(QUEUE_DEPTH)) begin
      sum = sum - SUM_W'(QUEUE_DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] head);
    return (head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head + PTR_W'(1);
  endfunction

  logic [7:0]       lcr_q, lcr_d, ier_q, ier_d, mcr_q, mcr_d;
  logic [7:0]       dll_q, dll_d, dlm_q, dlm_d, scr_q, scr_d;
  logic             qen_q, qen_d, busy_q, busy_d, overrun_q, overrun_d;
  logic [PTR_W-1:0] rx_head_q, rx_head_d, tx_head_q, tx_head_d;
  logic [CNT_W-1:0] rx_count_q, rx_count_d, tx_count_q, tx_count_d;

  logic [5:0]        reg_num;
  logic              reg_ok;
  uart_rb_pkg::reg_e reg_sel;
  logic              dlab;
  logic              rx_full, tx_full;
  logic              fcr_en, fcr_changed;
  logic [PTR_W-1:0]  rx_tail, tx_tail;

  // register decode
  assign reg_num = item_i.byte_offset >> stride_i;
  assign reg_ok  = (reg_num[5:3] == 3'd0);
  assign reg_sel = uart_rb_pkg::reg_e'(reg_num[2:0]);
  assign dlab    = lcr_q[uart_rb_pkg::LCR_DLAB_BIT];

  // queue fill state; a disabled queue holds one entry
  assign rx_full = qen_q ? (rx_count_q == CNT_W'(QUEUE_DEPTH)) : (rx_count_q != '0);
  assign tx_full = qen_q ? (tx_count_q == CNT_W'(QUEUE_DEPTH)) : (tx_count_q != '0);
  assign rx_tail = wrap_add(rx_head_q, rx_count_q);
  assign tx_tail = wrap_add(tx_head_q, tx_count_q);

  assign fcr_en      = item_i.write_data[uart_rb_pkg::FCR_EN_BIT];
  assign fcr_changed = (fcr_en != qen_q);

  assign rx_wdata_o = item_i.line_byte;
  assign tx_wdata_o = item_i.write_data;
  assign rx_raddr_o = rx_head_q;
  assign tx_raddr_o = tx_head_q;

  // item decode and next state
  always_comb begin
    lcr_d      = lcr_q;
    ier_d      = ier_q;
    mcr_d      = mcr_q;
    dll_d      = dll_q;
    dlm_d      = dlm_q;
    scr_d      = scr_q;
    qen_d      = qen_q;
    busy_d     = busy_q;
    overrun_d  = overrun_q;
    rx_head_d  = rx_head_q;
    rx_count_d = rx_count_q;
    tx_head_d  = tx_head_q;
    tx_count_d = tx_count_q;
    meta_o     = '0;
    rx_we_o    = 1'b0;
    rx_waddr_o = rx_tail;
    rx_re_o    = 1'b0;
    tx_we_o    = 1'b0;
    tx_waddr_o = tx_tail;
    tx_re_o    = 1'b0;
    if (accept_i) begin
      unique case (item_i.kind)
        uart_rb_pkg::KIND_READ: begin
          if (reg_ok) begin
            unique case (reg_sel)
              uart_rb_pkg::REG_DATA: begin
                if (dlab) begin
                  meta_o.rd_const = dll_q;
                end else if (rx_count_q != '0) begin
                  rx_re_o           = 1'b1;
                  meta_o.rd_from_rx = 1'b1;
                  rx_head_d         = ptr_inc(rx_head_q);
                  rx_count_d        = rx_count_q - CNT_W'(1);
                end
              end
              uart_rb_pkg::REG_IER:  meta_o.rd_const = dlab ? dlm_q : ier_q;
              uart_rb_pkg::REG_FIFO: begin
                meta_o.rd_const = qen_q ? uart_rb_pkg::IIR_FIFO_ON
                                        : uart_rb_pkg::IIR_FIFO_OFF;
              end
              uart_rb_pkg::REG_LCR:  meta_o.rd_const = lcr_q;
              uart_rb_pkg::REG_MCR:  meta_o.rd_const = mcr_q;
              uart_rb_pkg::REG_LSR: begin
                meta_o.rd_const =
                    ((rx_count_q != '0) ? uart_rb_pkg::LSR_DR : 8'h00) |
                    (overrun_q ? uart_rb_pkg::LSR_OE : 8'h00) |
                    ((tx_count_q == '0) ? uart_rb_pkg::LSR_TXQ_EMPTY : 8'h00) |
                    ((tx_count_q == '0 && !busy_q) ? uart_rb_pkg::LSR_TEMT : 8'h00);
                overrun_d = 1'b0;
              end
              uart_rb_pkg::REG_MSR:  meta_o.rd_const = 8'h00;
              uart_rb_pkg::REG_SCR:  meta_o.rd_const = scr_q;
            endcase
          end
        end
        uart_rb_pkg::KIND_WRITE: begin
          if (reg_ok) begin
            unique case (reg_sel)
              uart_rb_pkg::REG_DATA: begin
                if (dlab) begin
                  dll_d = item_i.write_data;
                end else if (!busy_q && tx_count_q == '0) begin
                  // idle shifter takes the byte directly
                  busy_d            = 1'b1;
                  meta_o.send_valid = 1'b1;
                  meta_o.sb_const   = item_i.write_data;
                end else if (!tx_full) begin
                  tx_we_o    = 1'b1;
                  tx_count_d = tx_count_q + CNT_W'(1);
                end
              end
              uart_rb_pkg::REG_IER: begin
                if (dlab) begin
                  dlm_d = item_i.write_data;
                end else begin
                  ier_d = item_i.write_data & uart_rb_pkg::IER_MASK;
                end
              end
              uart_rb_pkg::REG_FIFO: begin
                qen_d = fcr_en;
                if (fcr_changed || item_i.write_data[uart_rb_pkg::FCR_RXCLR_BIT]) begin
                  rx_head_d  = '0;
                  rx_count_d = '0;
                end
                if (fcr_changed || item_i.write_data[uart_rb_pkg::FCR_TXCLR_BIT]) begin
                  tx_head_d  = '0;
                  tx_count_d = '0;
                end
              end
              uart_rb_pkg::REG_LCR:  lcr_d = item_i.write_data;
              uart_rb_pkg::REG_MCR:  mcr_d = item_i.write_data & uart_rb_pkg::MCR_MASK;
              uart_rb_pkg::REG_LSR:  lcr_d = lcr_q;
              uart_rb_pkg::REG_MSR:  lcr_d = lcr_q;
              uart_rb_pkg::REG_SCR:  scr_d = item_i.write_data;
            endcase
          end
        end
        uart_rb_pkg::KIND_LINE: begin
          if (!rx_full) begin
            rx_we_o    = 1'b1;
            rx_count_d = rx_count_q + CNT_W'(1);
          end else begin
            overrun_d = 1'b1;
            // single holding register gets overwritten
            if (!qen_q) begin
              rx_we_o    = 1'b1;
              rx_waddr_o = rx_head_q;
            end
          end
        end
        uart_rb_pkg::KIND_DONE: begin
          if (busy_q) begin
            if (tx_count_q != '0) begin
              tx_re_o           = 1'b1;
              meta_o.send_valid = 1'b1;
              meta_o.sb_from_tx = 1'b1;
              tx_head_d         = ptr_inc(tx_head_q);
              tx_count_d        = tx_count_q - CNT_W'(1);
            end else begin
              busy_d = 1'b0;
            end
          end
        end
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lcr_q      <= '0;
      ier_q      <= '0;
      mcr_q      <= '0;
      dll_q      <= '0;
      dlm_q      <= '0;
      scr_q      <= '0;
      qen_q      <= 1'b0;
      busy_q     <= 1'b0;
      overrun_q  <= 1'b0;
      rx_head_q  <= '0;
      rx_count_q <= '0;
      tx_head_q  <= '0;
      tx_count_q <= '0;
    end else begin
      lcr_q      <= lcr_d;
      ier_q      <= ier_d;
      mcr_q      <= mcr_d;
      dll_q      <= dll_d;
      dlm_q      <= dlm_d;
      scr_q      <= scr_d;
      qen_q      <= qen_d;
      busy_q     <= busy_d;
      overrun_q  <= overrun_d;
      rx_head_q  <= rx_head_d;
      rx_count_q <= rx_count_d;
      tx_head_q  <= tx_head_d;
      tx_count_q <= tx_count_d;
    end
  end

`ifndef SYNTHESIS
  // receive fill never passes the queue depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_count_q <= CNT_W'(QUEUE_DEPTH))
    else $error("receive count beyond queue depth");

  // with the queues off each one holds at most one entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !qen_q |-> (rx_count_q <= CNT_W'(1) && tx_count_q <= CNT_W'(1)))
    else $error("disabled queue holds more than one entry");

  // queued transmit bytes imply a busy shifter
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_count_q != '0 |-> busy_q)
    else $error("transmit bytes queued behind an idle shifter");

  // a line byte into a full receive queue flags overrun
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && item_i.kind == uart_rb_pkg::KIND_LINE && rx_full) |=> overrun_q)
    else $error("overrun not flagged");
`endif

endmodule
